@@ hw/rtl/flv_first_av_tag_locator_assert.svh @@
// Assertion macros shared by the tag locator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef FLV_FIRST_AV_TAG_LOCATOR_ASSERT_SVH
`define FLV_FIRST_AV_TAG_LOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLVTL_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FLVTL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ hw/rtl/flvtl_pkg.sv @@
// Shared types and constants for the FLV first audio/video tag locator.
// Depends on nothing; used by flvtl_cfg_regs and the top level.
`timescale 1ns / 1ps
`default_nettype none

package flvtl_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BASE_OFFSET    = 2'd0,
        CFG_BUFFER_LENGTH  = 2'd1,
        CFG_AUDIO_TAG_TYPE = 2'd2,
        CFG_VIDEO_TAG_TYPE = 2'd3
    } t_cfg_index;

    // Configuration values seen by the walker.
    typedef struct packed {
        logic [31:0] base_offset;
        logic [31:0] buffer_length;
        logic [7:0]  audio_tag_type;
        logic [7:0]  video_tag_type;
    } t_cfg;

    localparam logic [7:0]  AUDIO_TYPE_RESET = 8'd8;
    localparam logic [7:0]  VIDEO_TYPE_RESET = 8'd9;

    // Position of the last byte of the leading previous-tag-size field.
    localparam logic [31:0] PREV_SIZE_LAST   = 32'd3;
    // A tag header is 11 bytes; the end offset counts from the type byte.
    localparam logic [31:0] TAG_HDR_LEN      = 32'd11;
    // Header (11) + data + previous size (4) + next header (11) must fit.
    localparam logic [32:0] NEED_EXTRA       = 33'd26;
    // Bytes skipped after the size field, added to the data size: rest of header (7) + previous size (4).
    localparam logic [24:0] TAIL_SKIP        = 25'd11;
    // Number of data size bytes.
    localparam logic [24:0] SIZE_BYTES       = 25'd3;

endpackage

`default_nettype wire

@@ hw/rtl/flv_first_av_tag_locator.sv @@
// Channel  Direction  Handshake                 Payload
// in       sink       i_in_valid / o_in_ready   i_data_byte, i_first_byte
// out      source     o_out_valid / i_out_ready o_status, o_audio_found, o_video_found,
//                                               o_audio_end, o_video_end
// cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle while o_in_ready is high; the walker state updates in the same cycle.
// A result is registered on the edge that takes the third size byte of a tag
// and is offered on the output the next cycle.
// o_in_ready is low only while a result is held and the sink stalls it.
// Reset is synchronous, active low; configuration writes are always taken.
// Depends on flvtl_pkg, flvtl_cfg_regs and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "flv_first_av_tag_locator_assert.svh"

module flv_first_av_tag_locator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic        o_status,
    output      logic        o_audio_found,
    output      logic        o_video_found,
    output      logic [31:0] o_audio_end,
    output      logic [31:0] o_video_end,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    typedef enum logic [1:0] {
        PH_PREV,
        PH_TYPE,
        PH_SIZE,
        PH_BODY
    } t_phase;

    flvtl_pkg::t_cfg w_cfg;

    // Walker state.
    t_phase      r_phase,     n_phase;
    logic [31:0] r_pos,       n_pos;
    logic [24:0] r_skip,      n_skip;
    logic [7:0]  r_type,      n_type;
    logic [15:0] r_size,      n_size;
    logic [31:0] r_end_base,  n_end_base;
    logic [32:0] r_need_base, n_need_base;
    logic        r_a_seen,    n_a_seen;
    logic        r_v_seen,    n_v_seen;
    logic [31:0] r_a_end,     n_a_end;
    logic [31:0] r_v_end,     n_v_end;
    logic        r_done,      n_done;

    // Result register.
    logic        r_out_valid;
    logic        r_status;
    logic        r_a_found;
    logic        r_v_found;
    logic [31:0] r_a_out;
    logic [31:0] r_v_out;

    logic        w_in_fire;
    logic        w_push;
    logic        w_status;

    // Walker state after a possible restart marker.
    t_phase      c_phase;
    logic [31:0] c_pos;
    logic        c_a_seen;
    logic        c_v_seen;
    logic [31:0] c_a_end;
    logic [31:0] c_v_end;
    logic        c_done;

    logic [23:0] w_size_new;
    logic [24:0] w_skip_dec;
    logic [31:0] w_end;
    logic [33:0] w_need;
    logic        w_is_audio;
    logic        w_is_video;

    flvtl_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;

    // Shared arithmetic for the last size byte of a tag. The base offset is
    // taken at this point, so a register write between tags is honored.
    assign w_size_new = {r_size, i_data_byte};
    assign w_skip_dec = r_skip - 25'd1;
    assign w_end      = w_cfg.base_offset + r_end_base + {8'd0, w_size_new};
    assign w_need     = {1'b0, r_need_base} + {10'd0, w_size_new};
    assign w_is_audio = (r_type == w_cfg.audio_tag_type);
    assign w_is_video = !w_is_audio && (r_type == w_cfg.video_tag_type);

    // A first-byte marker restarts the walk before the byte is used.
    always_comb begin
        if (i_first_byte) begin
            c_phase  = PH_PREV;
            c_pos    = '0;
            c_a_seen = 1'b0;
            c_v_seen = 1'b0;
            c_a_end  = '0;
            c_v_end  = '0;
            c_done   = 1'b0;
        end else begin
            c_phase  = r_phase;
            c_pos    = r_pos;
            c_a_seen = r_a_seen;
            c_v_seen = r_v_seen;
            c_a_end  = r_a_end;
            c_v_end  = r_v_end;
            c_done   = r_done;
        end
    end

    // Next walker state for an accepted byte.
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_skip      = r_skip;
        n_type      = r_type;
        n_size      = r_size;
        n_end_base  = r_end_base;
        n_need_base = r_need_base;
        n_a_seen    = r_a_seen;
        n_v_seen    = r_v_seen;
        n_a_end     = r_a_end;
        n_v_end     = r_v_end;
        n_done      = r_done;
        w_push      = 1'b0;
        w_status    = 1'b0;

        if (w_in_fire) begin
            n_phase  = c_phase;
            n_pos    = c_pos;
            n_a_seen = c_a_seen;
            n_v_seen = c_v_seen;
            n_a_end  = c_a_end;
            n_v_end  = c_v_end;
            n_done   = c_done;

            if (!c_done) begin
                n_pos = c_pos + 32'd1;
                case (c_phase)
                    PH_PREV: begin
                        if (c_pos >= flvtl_pkg::PREV_SIZE_LAST) begin
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        n_type      = i_data_byte;
                        n_size      = '0;
                        n_skip      = flvtl_pkg::SIZE_BYTES;
                        n_end_base  = c_pos + flvtl_pkg::TAG_HDR_LEN;
                        n_need_base = {1'b0, c_pos} + flvtl_pkg::NEED_EXTRA;
                        n_phase     = PH_SIZE;
                    end
                    PH_SIZE: begin
                        n_size = w_size_new[15:0];
                        n_skip = w_skip_dec;
                        if (w_skip_dec == '0) begin
                            // Record the first tag of each kind.
                            if (w_is_audio && !c_a_seen) begin
                                n_a_seen = 1'b1;
                                n_a_end  = w_end;
                            end
                            if (w_is_video && !c_v_seen) begin
                                n_v_seen = 1'b1;
                                n_v_end  = w_end;
                            end
                            if (n_a_seen && n_v_seen) begin
                                w_push = 1'b1;
                                n_done = 1'b1;
                            end else if ({2'b00, w_cfg.buffer_length} < w_need) begin
                                w_push   = 1'b1;
                                w_status = 1'b1;
                                n_done   = 1'b1;
                            end else begin
                                n_skip  = {1'b0, w_size_new} + flvtl_pkg::TAIL_SKIP;
                                n_phase = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        n_skip = w_skip_dec;
                        if (w_skip_dec == '0) begin
                            n_phase = PH_TYPE;
                        end
                    end
                    default: n_phase = PH_PREV;
                endcase
            end
        end
    end

    // Walker state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREV;
            r_pos       <= '0;
            r_a_seen    <= 1'b0;
            r_v_seen    <= 1'b0;
            r_a_end     <= '0;
            r_v_end     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_a_seen <= n_a_seen;
            r_v_seen <= n_v_seen;
            r_a_end  <= n_a_end;
            r_v_end  <= n_v_end;
            r_done   <= n_done;
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_skip      <= n_skip;
        r_type      <= n_type;
        r_size      <= n_size;
        r_end_base  <= n_end_base;
        r_need_base <= n_need_base;
        if (w_push) begin
            r_status  <= w_status;
            r_a_found <= n_a_seen;
            r_v_found <= n_v_seen;
            r_a_out   <= n_a_end;
            r_v_out   <= n_v_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_audio_found = r_a_found;
    assign o_video_found = r_v_found;
    assign o_audio_end   = r_a_out;
    assign o_video_end   = r_v_out;

    // A success beat always reports both tags.
    `FLVTL_ASSERT_NOW(a_success_both, i_clk, i_rst_n, o_out_valid && !o_status, o_audio_found && o_video_found)
    // An audio end offset that was never recorded reads as zero.
    `FLVTL_ASSERT_NOW(a_audio_end_zero, i_clk, i_rst_n, !r_a_seen, r_a_end == 32'd0)
    // Emitting a result closes the walk until the next marker.
    `FLVTL_ASSERT_NEXT(a_done_after_push, i_clk, i_rst_n, w_push, r_done && o_out_valid)

endmodule

`default_nettype wire

@@ hw/rtl/flvtl_cfg_regs.sv @@
// Configuration register file for the tag locator.
// Depends on flvtl_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps
`default_nettype none

module flvtl_cfg_regs (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    output flvtl_pkg::t_cfg           o_cfg
);

    flvtl_pkg::t_cfg r_cfg;
    flvtl_pkg::t_cfg n_cfg;

    // Decode the write beat into the next register contents.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (flvtl_pkg::t_cfg_index'(i_cfg_index))
                flvtl_pkg::CFG_BASE_OFFSET:    n_cfg.base_offset    = i_cfg_data;
                flvtl_pkg::CFG_BUFFER_LENGTH:  n_cfg.buffer_length  = i_cfg_data;
                flvtl_pkg::CFG_AUDIO_TAG_TYPE: n_cfg.audio_tag_type = i_cfg_data[7:0];
                flvtl_pkg::CFG_VIDEO_TAG_TYPE: n_cfg.video_tag_type = i_cfg_data[7:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_offset    <= '0;
            r_cfg.buffer_length  <= '0;
            r_cfg.audio_tag_type <= flvtl_pkg::AUDIO_TYPE_RESET;
            r_cfg.video_tag_type <= flvtl_pkg::VIDEO_TYPE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire
